// ----- rtl/skt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

   localparam int CAPACITY = 256;
   localparam int KEY_BITS = 32;

   localparam int IDX_BITS = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int POS_BITS = 8;
   localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   // first-hit search runs over groups of cells
   localparam int GROUP_SIZE   = 16;
   localparam int GSEL_BITS    = $clog2(GROUP_SIZE);
   localparam int GROUP_COUNT  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_CAPACITY = GROUP_COUNT * GROUP_SIZE;
   localparam int FIND_BITS    = $clog2(PAD_CAPACITY);

   // csr byte address of signed_compare
   localparam logic [1:0] CSR_SIGNED_CMP = 2'd0;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   localparam key_type KEY_SIGN = key_type'(1) << (KEY_BITS - 1);

   typedef enum logic [2:0] {
      KIND_INSERT     = 3'd0,
      KIND_REMOVE_KEY = 3'd1,
      KIND_SEARCH     = 3'd2,
      KIND_READ_INDEX = 3'd3,
      KIND_REMOVE_IDX = 3'd4,
      KIND_CLEAR      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      HIT_NOT_LESS = 2'd0,
      HIT_EQUAL    = 2'd1,
      HIT_POSITION = 2'd2
   } hit_mode_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic         capture;
      hit_mode_type mode;
      logic         insert_en;
      logic         remove_en;
      idx_type      slot;
      key_type      key;
      logic         signed_cmp;
      cnt_type      count;
      logic         pos_ok;
      idx_type      position;
   } cell_ctrl_type;

   typedef struct packed {
      logic    any;
      idx_type index;
      key_type key;
   } find_type;

   function automatic logic key_less(key_type a, key_type b, logic signed_cmp);
      key_type sa;
      key_type sb;
      sa = signed_cmp ? (a ^ KEY_SIGN) : a;
      sb = signed_cmp ? (b ^ KEY_SIGN) : b;
      return sa < sb;
   endfunction

   function automatic key_type key_from_port(logic [31:0] k);
      logic [63:0] w;
      w = 64'(k);
      return w[KEY_BITS-1:0];
   endfunction

   function automatic logic [31:0] key_to_port(key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[31:0];
   endfunction

   function automatic idx_type idx_from_pos(logic [POS_BITS-1:0] p);
      logic [15:0] w;
      w = 16'(p);
      return w[IDX_BITS-1:0];
   endfunction

   function automatic logic [7:0] idx_to_port(idx_type i);
      logic [15:0] w;
      w = 16'(i);
      return w[7:0];
   endfunction

   function automatic logic [8:0] cnt_to_port(cnt_type c);
      logic [15:0] w;
      w = 16'(c);
      return w[8:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/skt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
   input  wire                    clock,
   input  skt_pkg::idx_type       my_index,
   input  skt_pkg::cell_ctrl_type ctrl,
   input  skt_pkg::key_type       left_key,
   input  skt_pkg::key_type       right_key,
   output skt_pkg::key_type       key_out,
   output logic                   hit_out
);
   import skt_pkg::*;

   key_type key_ff;
   key_type key_in;
   logic    hit_ff;
   logic    hit_in;
   logic    occupied;
   logic    less;
   logic    equal;

   always_comb begin
      occupied = cnt_type'(my_index) < ctrl.count;
      less     = occupied && key_less(key_ff, ctrl.key, ctrl.signed_cmp);
      equal    = occupied && (key_ff == ctrl.key);

      case (ctrl.mode)
         HIT_NOT_LESS: hit_in = !less;
         HIT_EQUAL:    hit_in = equal;
         HIT_POSITION: hit_in = ctrl.pos_ok && (ctrl.position == my_index);
         default:      hit_in = 1'b0;
      endcase

      // open a slot by taking the left neighbor, close one by taking the right
      key_in = key_ff;
      if (ctrl.insert_en) begin
         if (my_index > ctrl.slot) begin
            key_in = left_key;
         end else if (my_index == ctrl.slot) begin
            key_in = ctrl.key;
         end
      end else if (ctrl.remove_en) begin
         if (my_index >= ctrl.slot) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctrl.capture) begin
         hit_ff <= hit_in;
      end
   end

   assign key_out = key_ff;
   assign hit_out = hit_ff;

endmodule

`default_nettype wire

// ----- rtl/skt_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skt_finder (
   input  wire              clock,
   input  logic             hits [skt_pkg::PAD_CAPACITY],
   input  skt_pkg::key_type keys [skt_pkg::PAD_CAPACITY],
   output skt_pkg::find_type result
);
   import skt_pkg::*;

   logic                 grp_any_in [GROUP_COUNT];
   logic [GSEL_BITS-1:0] grp_sel_in [GROUP_COUNT];
   key_type              grp_key_in [GROUP_COUNT];
   logic                 grp_any_ff [GROUP_COUNT];
   logic [GSEL_BITS-1:0] grp_sel_ff [GROUP_COUNT];
   key_type              grp_key_ff [GROUP_COUNT];
   find_type             find_in;
   find_type             find_ff;

   // first stage: lowest hit inside each group
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_any_in[g] = 1'b0;
         grp_sel_in[g] = '0;
         grp_key_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (hits[g*GROUP_SIZE + j]) begin
               grp_any_in[g] = 1'b1;
               grp_sel_in[g] = GSEL_BITS'(j);
               grp_key_in[g] = keys[g*GROUP_SIZE + j];
            end
         end
      end
   end

   // second stage: lowest group with a hit
   always_comb begin
      logic [FIND_BITS-1:0] full;
      find_in = '0;
      full    = '0;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            full          = (FIND_BITS'(g) << GSEL_BITS) | FIND_BITS'(grp_sel_ff[g]);
            find_in.any   = 1'b1;
            find_in.index = idx_type'(full);
            find_in.key   = grp_key_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_any_ff[g] <= grp_any_in[g];
         grp_sel_ff[g] <= grp_sel_in[g];
         grp_key_ff[g] <= grp_key_in[g];
      end
      find_ff <= find_in;
   end

   assign result = find_ff;

endmodule

`default_nettype wire

// ----- rtl/sorted_key_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// sorted key table: ascending keys held in a row of compare-and-shift cells
// result: registered after the compare, find and apply states; apply waits while
//   the output stalls; a new request waits for the cell compare, the two-level
//   first-hit search over the cell row and the shift pass
// reset: entry count and signed_compare go to zero; cell keys are not cleared
module sorted_key_table (
   input  wire         clock,
   input  wire         reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_key,
   input  logic [7:0]  req_position,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_found_index,
   output logic [31:0] rsp_found_key,
   output logic [8:0]  rsp_entry_count,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import skt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_FIND1,
      S_FIND2,
      S_APPLY
   } state_type;

   state_type        state_ff, state_in;
   cnt_type          count_ff, count_in;
   logic             signed_ff, signed_in;
   kind_type         kind_ff, kind_in;
   key_type          key_ff, key_in;
   logic [7:0]       pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_index_ff, rsp_index_in;
   logic [31:0]      rsp_key_ff, rsp_key_in;
   logic [8:0]       rsp_count_ff, rsp_count_in;

   cell_ctrl_type    ctrl;
   find_type         find;
   key_type          cell_key [PAD_CAPACITY];
   logic             cell_hit [PAD_CAPACITY];

   logic             csr_write;
   logic             accept;
   logic             out_free;
   logic             apply_go;
   logic             pos_in_table;
   logic             pos_below_count;
   logic             do_insert;
   logic             do_remove;
   idx_type          remove_slot;

   // ---------------- configuration port ----------------
   // one register, signed_compare, at byte address zero
   assign csr_write = psel && penable && pwrite && (paddr == CSR_SIGNED_CMP);
   assign pready    = 1'b1;
   assign prdata    = (paddr == CSR_SIGNED_CMP) ? {31'd0, signed_ff} : 32'd0;

   // ---------------- request side ----------------
   // one request in flight; the output register frees the input side early
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign apply_go  = (state_ff == S_APPLY) && out_free;

   assign pos_in_table    = CMP_BITS'(pos_ff) < CMP_BITS'(CAPACITY);
   assign pos_below_count = CMP_BITS'(pos_ff) < CMP_BITS'(count_ff);

   // ---------------- outcome of the current request ----------------
   always_comb begin
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      remove_slot   = find.index;
      rsp_status_in = ST_OK;
      rsp_index_in  = '0;
      rsp_key_in    = '0;
      count_in      = count_ff;

      case (kind_ff)
         KIND_INSERT: begin
            if (count_ff == cnt_type'(CAPACITY)) begin
               rsp_status_in = ST_FULL;
            end else begin
               // a not-less cell always exists below a non-full count
               do_insert    = 1'b1;
               rsp_index_in = idx_to_port(find.index);
               rsp_key_in   = key_to_port(key_ff);
               count_in     = count_ff + cnt_type'(1);
            end
         end
         KIND_REMOVE_KEY: begin
            // lower slot must be occupied and hold the very key
            if (find.any && (cnt_type'(find.index) < count_ff) && (find.key == key_ff)) begin
               do_remove    = 1'b1;
               rsp_index_in = idx_to_port(find.index);
               rsp_key_in   = key_to_port(key_ff);
               count_in     = count_ff - cnt_type'(1);
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         KIND_SEARCH: begin
            if (find.any) begin
               rsp_index_in = idx_to_port(find.index);
               rsp_key_in   = key_to_port(key_ff);
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         KIND_READ_INDEX: begin
            if (pos_below_count) begin
               rsp_index_in = pos_ff;
               rsp_key_in   = key_to_port(find.key);
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         KIND_REMOVE_IDX: begin
            if (pos_below_count) begin
               do_remove    = 1'b1;
               remove_slot  = idx_from_pos(pos_ff);
               rsp_index_in = pos_ff;
               rsp_key_in   = key_to_port(find.key);
               count_in     = count_ff - cnt_type'(1);
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            // unused kinds leave the table alone
         end
      endcase
      rsp_count_in = cnt_to_port(count_in);
   end

   // ---------------- broadcast to the cell row ----------------
   always_comb begin
      ctrl            = '0;
      ctrl.capture    = (state_ff == S_COMPARE);
      ctrl.key        = key_ff;
      ctrl.signed_cmp = signed_ff;
      ctrl.count      = count_ff;
      ctrl.pos_ok     = pos_in_table;
      ctrl.position   = idx_from_pos(pos_ff);
      ctrl.insert_en  = apply_go && do_insert;
      ctrl.remove_en  = apply_go && do_remove;
      ctrl.slot       = do_insert ? find.index : remove_slot;
      case (kind_ff)
         KIND_INSERT:     ctrl.mode = HIT_NOT_LESS;
         KIND_REMOVE_KEY: ctrl.mode = HIT_NOT_LESS;
         KIND_SEARCH:     ctrl.mode = HIT_EQUAL;
         default:         ctrl.mode = HIT_POSITION;
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      signed_in    = csr_write ? pwdata[0] : signed_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = kind_type'(req_kind);
               key_in   = key_from_port(req_key);
               pos_in   = req_position;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: state_in = S_FIND1;
         S_FIND1:   state_in = S_FIND2;
         S_FIND2:   state_in = S_APPLY;
         S_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         signed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         signed_ff    <= signed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_go) begin
            count_ff <= count_in;
         end
      end
      kind_ff <= kind_in;
      key_ff  <= key_in;
      pos_ff  <= pos_in;
      if (apply_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_found_key   = rsp_key_ff;
   assign rsp_entry_count = rsp_count_ff;

   // ---------------- cell row ----------------
   // cell i holds entry i; neighbors pass keys on insert and removal
   for (genvar i = 0; i < PAD_CAPACITY; i++) begin : g_cell
      if (i < CAPACITY) begin : g_real
         key_type left_key;
         key_type right_key;
         if (i == 0) begin : g_first
            assign left_key = key_ff;
         end else begin : g_inner_left
            assign left_key = cell_key[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[i];
         end else begin : g_inner_right
            assign right_key = cell_key[i+1];
         end
         skt_cell u_cell (
            .clock     (clock),
            .my_index  (idx_type'(i)),
            .ctrl      (ctrl),
            .left_key  (left_key),
            .right_key (right_key),
            .key_out   (cell_key[i]),
            .hit_out   (cell_hit[i])
         );
      end else begin : g_pad
         // group padding never hits
         assign cell_key[i] = '0;
         assign cell_hit[i] = 1'b0;
      end
   end

   // first hit over the row, two registered levels
   skt_finder u_finder (
      .clock  (clock),
      .hits   (cell_hit),
      .keys   (cell_key),
      .result (find)
   );

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_COMPARE)
      else $error("accepted request did not start the compare");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) && !out_free |=> $stable(count_ff))
      else $error("table changed while result was held back");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |->
         (rsp_index_ff == 8'd0) && (rsp_key_ff == 32'd0))
      else $error("failed request carries index or key");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      apply_go && (rsp_status_in == ST_FULL) |-> count_ff == cnt_type'(CAPACITY))
      else $error("full status with room left");
`endif

endmodule

`default_nettype wire
